>>> rtl/vdr_pkg.sv
// Shared types, constants and helper functions for the vector displace and reflect block.
// Depends on nothing; used by vector_displace_and_reflect.
package vdr_pkg;

   localparam int COORD_W = 32;
   localparam int ANGLE_W = 25;
   localparam int MAG_W   = 31;

   localparam int DEF_FRAC_BITS    = 16;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int ATAN_N           = 24;

   localparam logic CMD_DISPLACE = 1'b0;
   localparam logic CMD_REFLECT  = 1'b1;

   localparam int UNITS_W = 44;
   localparam int Z_W     = UNITS_W + 2;
   localparam int XY_W    = 34;
   localparam int SUM_W   = 38;
   localparam int Q30     = 30;

   localparam longint DEG_UNITS   = 64'd100000000000;
   localparam int     UNITS_SPLIT = 20;
   localparam int     UNITS_HI_W  = 17;
   localparam int     UNITS_LO_W  = 19;
   localparam logic [UNITS_HI_W-1:0] UNITS_HI = 17'd95367;
   localparam logic [UNITS_LO_W-1:0] UNITS_LO = 19'd452608;

   localparam logic signed [31:0] CORDIC_K = 32'sh26DD3B6A;

   typedef struct packed {
      logic                      cmd;
      logic                      polar;
      logic                      side_wall;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] delta_x;
      logic signed [COORD_W-1:0] delta_y;
      logic [ANGLE_W-1:0]        angle;
      logic [MAG_W-1:0]          magnitude;
      logic                      fold_neg;
      logic                      fold_flip;
   } vdr_item_type;

   // Arctangent of 2^-idx in units of 1e-11 degree, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_units(input logic [4:0] idx);
      case (idx)
         5'd0:  atan_units = 46'sd4500000000000;
         5'd1:  atan_units = 46'sd2656505117708;
         5'd2:  atan_units = 46'sd1403624346793;
         5'd3:  atan_units = 46'sd712501634890;
         5'd4:  atan_units = 46'sd357633437500;
         5'd5:  atan_units = 46'sd178991060825;
         5'd6:  atan_units = 46'sd89517371021;
         5'd7:  atan_units = 46'sd44761417086;
         5'd8:  atan_units = 46'sd22381050037;
         5'd9:  atan_units = 46'sd11190567707;
         5'd10: atan_units = 46'sd5595289189;
         5'd11: atan_units = 46'sd2797645262;
         5'd12: atan_units = 46'sd1398822714;
         5'd13: atan_units = 46'sd699411368;
         5'd14: atan_units = 46'sd349705685;
         5'd15: atan_units = 46'sd174852843;
         5'd16: atan_units = 46'sd87426421;
         5'd17: atan_units = 46'sd43713211;
         5'd18: atan_units = 46'sd21856605;
         5'd19: atan_units = 46'sd10928303;
         5'd20: atan_units = 46'sd5464151;
         5'd21: atan_units = 46'sd2732076;
         5'd22: atan_units = 46'sd1366038;
         5'd23: atan_units = 46'sd683019;
         default: atan_units = '0;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
         sat32 = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat32 = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat32 = {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] neg_sat32(
      input logic signed [COORD_W-1:0] v
   );
      if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
         neg_sat32 = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         neg_sat32 = -v;
      end
   endfunction

endpackage

>>> rtl/vector_displace_and_reflect.sv
// Top level of the vector displace and reflect block: a fully pipelined datapath
// with angle reduction, angle folding, a CORDIC rotator and saturating adders.
// Depends on vdr_pkg.

// The block takes one word per clock cycle while busy is low and returns the results
// in the order the words were accepted; the pipeline depth is set by the CORDIC
// rotator, which spends one pipeline stage on each iteration. Results are strobed
// on rsp_valid for one cycle and are never held back, so the pipeline never stalls.
// Busy is high only during reset and the cycle after it.
module vector_displace_and_reflect #(
   parameter int FRAC_BITS    = vdr_pkg::DEF_FRAC_BITS,
   parameter int CORDIC_STEPS = vdr_pkg::DEF_CORDIC_STEPS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic                                req_polar,
   input  logic                                req_side_wall,
   input  logic signed [vdr_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [vdr_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [vdr_pkg::COORD_W-1:0]  req_delta_x,
   input  logic signed [vdr_pkg::COORD_W-1:0]  req_delta_y,
   input  logic [vdr_pkg::ANGLE_W-1:0]         req_angle,
   input  logic [vdr_pkg::MAG_W-1:0]           req_magnitude,
   output logic                                rsp_valid,
   output logic signed [vdr_pkg::COORD_W-1:0]  rsp_new_x,
   output logic signed [vdr_pkg::COORD_W-1:0]  rsp_new_y,
   output logic signed [vdr_pkg::COORD_W-1:0]  rsp_out_delta_x,
   output logic signed [vdr_pkg::COORD_W-1:0]  rsp_out_delta_y,
   output logic [vdr_pkg::ANGLE_W-1:0]         rsp_out_angle,
   output logic [vdr_pkg::MAG_W-1:0]           rsp_out_magnitude
);

   localparam int NS = (CORDIC_STEPS > vdr_pkg::ATAN_N) ? vdr_pkg::ATAN_N : CORDIC_STEPS;

   localparam int ST_CAP  = 0;
   localparam int ST_QUO  = 1;
   localparam int ST_MOD  = 2;
   localparam int ST_FOLD = 3;
   localparam int ST_PART = 4;
   localparam int ST_UNIT = 5;
   localparam int ST_ZED  = 6;
   localparam int ST_CRD  = 7;
   localparam int ST_FLIP = ST_CRD + NS;
   localparam int ST_MUL  = ST_FLIP + 1;
   localparam int ST_RND  = ST_MUL + 1;
   localparam int ST_OUT  = ST_RND + 1;
   localparam int LAT     = ST_OUT + 1;

   localparam longint FULL    = longint'(360) << FRAC_BITS;
   localparam longint HALF    = longint'(180) << FRAC_BITS;
   localparam longint QUARTER = longint'(90) << FRAC_BITS;
   localparam longint THREEQ  = longint'(270) << FRAC_BITS;

   localparam int     FULL_LOG = $clog2(FULL);
   localparam int     KSH      = vdr_pkg::ANGLE_W + FULL_LOG + 1;
   localparam longint RECIP    = ((longint'(1) << KSH) + FULL - 1) / FULL;
   localparam int     QW       = (vdr_pkg::ANGLE_W > FULL_LOG) ?
                                 vdr_pkg::ANGLE_W - FULL_LOG + 1 : 1;
   localparam int     PW       = KSH + QW;

   localparam int AW  = FRAC_BITS + 11;
   localparam int FMW = FRAC_BITS + 7;
   localparam int HPW = FMW + vdr_pkg::UNITS_HI_W;
   localparam int LPW = FMW + vdr_pkg::UNITS_LO_W;
   localparam int USW = HPW + vdr_pkg::UNITS_SPLIT + 1;

   localparam int UW  = vdr_pkg::UNITS_W;
   localparam int ZW  = vdr_pkg::Z_W;
   localparam int XW  = vdr_pkg::XY_W;
   localparam int MPW = vdr_pkg::MAG_W + 1 + XW;
   localparam int DW  = MPW - vdr_pkg::Q30;
   localparam int SW  = vdr_pkg::SUM_W;

   localparam logic signed [MPW-1:0] ROUND_HALF = MPW'(longint'(1) << (vdr_pkg::Q30 - 1));

   logic                        busy_ff;
   logic [LAT-1:0]              valid_ff;
   vdr_pkg::vdr_item_type       item_ff [LAT];
   vdr_pkg::vdr_item_type       cap_in;
   vdr_pkg::vdr_item_type       mod_item_in;
   vdr_pkg::vdr_item_type       fold_item_in;

   logic [PW-1:0]               quo_prod;
   logic [QW-1:0]               q_ff, q_in;
   logic [vdr_pkg::ANGLE_W-1:0] amod_in;
   logic [AW-1:0]               fa, oang;
   logic [FMW-1:0]              fm_ff, fm_in;
   logic                        fneg, fflip;
   logic [HPW-1:0]              ph_ff, ph_in;
   logic [LPW-1:0]              pl_ff, pl_in;
   logic [USW-1:0]              usum;
   logic [UW-1:0]               units_ff, units_in;
   logic signed [ZW-1:0]        zpos;
   logic signed [ZW-1:0]        z_ff, z_in;
   logic signed [XW-1:0]        cx_ff [NS];
   logic signed [XW-1:0]        cy_ff [NS];
   logic signed [ZW-1:0]        cz_ff [NS];
   logic signed [XW-1:0]        cos_ff, cos_in, sin_ff, sin_in;
   logic signed [MPW-1:0]       magx;
   logic signed [MPW-1:0]       prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [MPW-1:0]       rndx, rndy;
   logic signed [DW-1:0]        dispx_ff, dispx_in, dispy_ff, dispy_in;
   logic signed [SW-1:0]        addx, suby, sumx, sumy;
   logic signed [vdr_pkg::COORD_W-1:0] nx_ff, nx_in, ny_ff, ny_in;

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start & ~busy_ff};
      end
   end

   always_comb begin
      cap_in           = '0;
      cap_in.cmd       = req_cmd;
      cap_in.polar     = req_polar;
      cap_in.side_wall = req_side_wall;
      cap_in.pos_x     = req_pos_x;
      cap_in.pos_y     = req_pos_y;
      cap_in.delta_x   = req_delta_x;
      cap_in.delta_y   = req_delta_y;
      cap_in.angle     = req_angle;
      cap_in.magnitude = req_magnitude;
   end

   always_comb begin
      mod_item_in       = item_ff[ST_QUO];
      mod_item_in.angle = amod_in;
   end

   always_ff @(posedge clock) begin
      item_ff[ST_CAP] <= cap_in;
      for (int s = 1; s < LAT; s++) begin
         if (s == ST_MOD) begin
            item_ff[s] <= mod_item_in;
         end else if (s == ST_FOLD) begin
            item_ff[s] <= fold_item_in;
         end else begin
            item_ff[s] <= item_ff[s-1];
         end
      end
   end

   // Angle reduction: the quotient by a full turn comes from a reciprocal multiply.
   assign quo_prod = PW'(item_ff[ST_CAP].angle) * PW'(RECIP);
   assign q_in     = quo_prod[KSH +: QW];
   assign amod_in  = item_ff[ST_QUO].angle -
                     vdr_pkg::ANGLE_W'(longint'(q_ff) * FULL);

   // Fold into [-90,90] degrees and work out the reflected vector.
   assign fa = AW'(item_ff[ST_MOD].angle);

   always_comb begin
      if (fa <= AW'(QUARTER)) begin
         fm_in = FMW'(fa);
         fneg  = 1'b0;
         fflip = 1'b0;
      end else if (fa < AW'(HALF)) begin
         fm_in = FMW'(AW'(HALF) - fa);
         fneg  = 1'b1;
         fflip = 1'b1;
      end else if (fa < AW'(THREEQ)) begin
         fm_in = FMW'(fa - AW'(HALF));
         fneg  = 1'b0;
         fflip = 1'b1;
      end else begin
         fm_in = FMW'(AW'(FULL) - fa);
         fneg  = 1'b1;
         fflip = 1'b0;
      end
   end

   always_comb begin
      if (item_ff[ST_MOD].side_wall) begin
         oang = (fa <= AW'(HALF)) ? AW'(HALF) - fa : AW'(FULL + HALF) - fa;
      end else begin
         oang = (fa == '0) ? '0 : AW'(FULL) - fa;
      end
   end

   always_comb begin
      fold_item_in           = item_ff[ST_MOD];
      fold_item_in.fold_neg  = fneg;
      fold_item_in.fold_flip = fflip;
      if (item_ff[ST_MOD].cmd == vdr_pkg::CMD_REFLECT) begin
         if (item_ff[ST_MOD].polar) begin
            fold_item_in.angle = vdr_pkg::ANGLE_W'(oang);
         end else if (item_ff[ST_MOD].side_wall) begin
            fold_item_in.delta_x = vdr_pkg::neg_sat32(item_ff[ST_MOD].delta_x);
         end else begin
            fold_item_in.delta_y = vdr_pkg::neg_sat32(item_ff[ST_MOD].delta_y);
         end
      end
   end

   // Conversion to 1e-11 degree units, with the constant split into two products.
   assign ph_in    = HPW'(fm_ff) * HPW'(vdr_pkg::UNITS_HI);
   assign pl_in    = LPW'(fm_ff) * LPW'(vdr_pkg::UNITS_LO);
   assign usum     = (USW'(ph_ff) << vdr_pkg::UNITS_SPLIT) + USW'(pl_ff);
   assign units_in = UW'(usum >> FRAC_BITS);
   assign zpos     = signed'({2'b00, units_ff});
   assign z_in     = item_ff[ST_UNIT].fold_neg ? -zpos : zpos;

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      fm_ff    <= fm_in;
      ph_ff    <= ph_in;
      pl_ff    <= pl_in;
      units_ff <= units_in;
      z_ff     <= z_in;
   end

   for (genvar i = 0; i < NS; i++) begin : g_crd
      localparam logic signed [ZW-1:0] ATAN = vdr_pkg::atan_units(5'(i));
      logic signed [XW-1:0] x_prev, y_prev, x_next, y_next;
      logic signed [ZW-1:0] z_prev, z_next;

      if (i == 0) begin : g_first
         assign x_prev = XW'(vdr_pkg::CORDIC_K);
         assign y_prev = '0;
         assign z_prev = z_ff;
      end else begin : g_rest
         assign x_prev = cx_ff[i-1];
         assign y_prev = cy_ff[i-1];
         assign z_prev = cz_ff[i-1];
      end

      always_comb begin
         if (!z_prev[ZW-1]) begin
            x_next = x_prev - (y_prev >>> i);
            y_next = y_prev + (x_prev >>> i);
            z_next = z_prev - ATAN;
         end else begin
            x_next = x_prev + (y_prev >>> i);
            y_next = y_prev - (x_prev >>> i);
            z_next = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         cx_ff[i] <= x_next;
         cy_ff[i] <= y_next;
         cz_ff[i] <= z_next;
      end
   end

   // A fold through 180 degrees negates both cosine and sine.
   assign cos_in = item_ff[ST_FLIP-1].fold_flip ? -cx_ff[NS-1] : cx_ff[NS-1];
   assign sin_in = item_ff[ST_FLIP-1].fold_flip ? -cy_ff[NS-1] : cy_ff[NS-1];

   assign magx     = MPW'(signed'({1'b0, item_ff[ST_FLIP].magnitude}));
   assign prodx_in = magx * MPW'(cos_ff);
   assign prody_in = magx * MPW'(sin_ff);

   assign rndx     = (prodx_ff + ROUND_HALF) >>> vdr_pkg::Q30;
   assign rndy     = (prody_ff + ROUND_HALF) >>> vdr_pkg::Q30;
   assign dispx_in = DW'(rndx);
   assign dispy_in = DW'(rndy);

   assign addx = item_ff[ST_RND].polar ? SW'(dispx_ff) : SW'(item_ff[ST_RND].delta_x);
   assign suby = item_ff[ST_RND].polar ? SW'(dispy_ff) : SW'(item_ff[ST_RND].delta_y);
   assign sumx = SW'(item_ff[ST_RND].pos_x) + addx;
   assign sumy = SW'(item_ff[ST_RND].pos_y) - suby;
   assign nx_in = (item_ff[ST_RND].cmd == vdr_pkg::CMD_DISPLACE) ?
                  vdr_pkg::sat32(sumx) : item_ff[ST_RND].pos_x;
   assign ny_in = (item_ff[ST_RND].cmd == vdr_pkg::CMD_DISPLACE) ?
                  vdr_pkg::sat32(sumy) : item_ff[ST_RND].pos_y;

   always_ff @(posedge clock) begin
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
      prodx_ff <= prodx_in;
      prody_ff <= prody_in;
      dispx_ff <= dispx_in;
      dispy_ff <= dispy_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
   end

   assign rsp_valid         = valid_ff[ST_OUT];
   assign rsp_new_x         = nx_ff;
   assign rsp_new_y         = ny_ff;
   assign rsp_out_delta_x   = item_ff[ST_OUT].delta_x;
   assign rsp_out_delta_y   = item_ff[ST_OUT].delta_y;
   assign rsp_out_angle     = item_ff[ST_OUT].angle;
   assign rsp_out_magnitude = item_ff[ST_OUT].magnitude;

   // Every result word goes back to a word accepted at the pipeline input.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("Result word without a matching accepted word.");

   // The reduced angle lies below one full turn.
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_MOD] |-> (longint'(item_ff[ST_MOD].angle) < FULL))
      else $error("Angle reduction left a value at or above a full turn.");

   // The folded angle never exceeds a quarter turn.
   a_folded: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_FOLD] |-> (longint'(fm_ff) <= QUARTER))
      else $error("Folded angle exceeds a quarter turn.");

   // The CORDIC start angle stays within 90 degrees.
   a_units: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_UNIT] |-> (longint'(units_ff) <= longint'(90) * vdr_pkg::DEG_UNITS))
      else $error("Angle in degree units exceeds 90 degrees.");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for vector_displace_and_reflect: a queued driver, a result
// monitor and a bit-exact predictor of the CORDIC displacement and wall reflection.
// Depends on vdr_pkg and the vector_displace_and_reflect RTL.
module tb_top;

   localparam int     COORD_W    = vdr_pkg::COORD_W;
   localparam int     ANGLE_W    = vdr_pkg::ANGLE_W;
   localparam int     MAG_W      = vdr_pkg::MAG_W;
   localparam int     FRAC       = vdr_pkg::DEF_FRAC_BITS;
   localparam int     STEPS      = vdr_pkg::DEF_CORDIC_STEPS;
   localparam int     STEPS_USED = (STEPS > vdr_pkg::ATAN_N) ? vdr_pkg::ATAN_N : STEPS;
   localparam int     LATENCY    = 11 + STEPS_USED;
   localparam int     IDLE_LIMIT = 2000;
   localparam int     RANDOM_WORDS = 950;
   localparam longint ONE_DEG    = 64'sd1 << FRAC;
   localparam longint FULL_TURN  = 360 * ONE_DEG;
   localparam longint HALF_TURN  = 180 * ONE_DEG;
   localparam longint QUARTER    = 90 * ONE_DEG;
   localparam longint FRAC_MASK  = ONE_DEG - 1;
   localparam longint GAIN_START = 64'sd652032874;
   localparam longint UNITS_DEG  = 64'sd100000000000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
   localparam longint MAG_MAX   = 64'sh7FFFFFFF;
   localparam longint ANGLE_TOP = 64'sh1FFFFFF;

   typedef struct packed {
      logic                      cmd;
      logic                      polar;
      logic                      side_wall;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] delta_x;
      logic signed [COORD_W-1:0] delta_y;
      logic [ANGLE_W-1:0]        angle;
      logic [MAG_W-1:0]          magnitude;
      int unsigned               gap;
   } motion_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] new_x;
      logic signed [COORD_W-1:0] new_y;
      logic signed [COORD_W-1:0] out_delta_x;
      logic signed [COORD_W-1:0] out_delta_y;
      logic [ANGLE_W-1:0]        out_angle;
      logic [MAG_W-1:0]          out_magnitude;
   } motion_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = 1'b0;
   logic req_polar = 1'b0;
   logic req_side_wall = 1'b0;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_delta_x = '0;
   logic signed [COORD_W-1:0] req_delta_y = '0;
   logic [ANGLE_W-1:0]        req_angle = '0;
   logic [MAG_W-1:0]          req_magnitude = '0;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_new_x;
   logic signed [COORD_W-1:0] rsp_new_y;
   logic signed [COORD_W-1:0] rsp_out_delta_x;
   logic signed [COORD_W-1:0] rsp_out_delta_y;
   logic [ANGLE_W-1:0]        rsp_out_angle;
   logic [MAG_W-1:0]          rsp_out_magnitude;

   motion_word_type   word_backlog[$];
   motion_result_type predicted_motion_q[$];
   motion_word_type   staged_word;
   motion_word_type   live_word;
   logic           staged = 1'b0;
   int unsigned    hold_left = 0;
   int             mismatch_count = 0;
   int             results_checked = 0;
   int             idle_cycles = 0;
   int             kind_count[4] = '{0, 0, 0, 0};

   vector_displace_and_reflect #(
      .FRAC_BITS(FRAC),
      .CORDIC_STEPS(STEPS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_polar(req_polar),
      .req_side_wall(req_side_wall),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_delta_x(req_delta_x),
      .req_delta_y(req_delta_y),
      .req_angle(req_angle),
      .req_magnitude(req_magnitude),
      .rsp_valid(rsp_valid),
      .rsp_new_x(rsp_new_x),
      .rsp_new_y(rsp_new_y),
      .rsp_out_delta_x(rsp_out_delta_x),
      .rsp_out_delta_y(rsp_out_delta_y),
      .rsp_out_angle(rsp_out_angle),
      .rsp_out_magnitude(rsp_out_magnitude)
   );

   always #5 clock = ~clock;

   function automatic longint arctan_units(input int idx);
      case (idx)
         0:  return 64'sd4500000000000;
         1:  return 64'sd2656505117708;
         2:  return 64'sd1403624346793;
         3:  return 64'sd712501634890;
         4:  return 64'sd357633437500;
         5:  return 64'sd178991060825;
         6:  return 64'sd89517371021;
         7:  return 64'sd44761417086;
         8:  return 64'sd22381050037;
         9:  return 64'sd11190567707;
         10: return 64'sd5595289189;
         11: return 64'sd2797645262;
         12: return 64'sd1398822714;
         13: return 64'sd699411368;
         14: return 64'sd349705685;
         15: return 64'sd174852843;
         16: return 64'sd87426421;
         17: return 64'sd43713211;
         18: return 64'sd21856605;
         19: return 64'sd10928303;
         20: return 64'sd5464151;
         21: return 64'sd2732076;
         22: return 64'sd1366038;
         23: return 64'sd683019;
         default: return 64'sd0;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   function automatic longint round_q30(input longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic void unit_vector(input longint a, output longint c, output longint s);
      longint t;
      longint m;
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      int     i;
      t = a;
      flip = 1'b0;
      if (t > HALF_TURN) t = t - FULL_TURN;
      if (t > QUARTER) begin
         t = t - HALF_TURN;
         flip = 1'b1;
      end else if (t < -QUARTER) begin
         t = t + HALF_TURN;
         flip = 1'b1;
      end
      m = (t < 0) ? -t : t;
      z = (m >>> FRAC) * UNITS_DEG + (((m & FRAC_MASK) * UNITS_DEG) >>> FRAC);
      if (t < 0) z = -z;
      x = GAIN_START;
      y = 0;
      for (i = 0; i < STEPS_USED; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arctan_units(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arctan_units(i);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic motion_result_type predict_motion(input motion_word_type w);
      motion_result_type r;
      longint ang;
      longint mag;
      longint oang;
      longint c;
      longint s;
      ang = longint'({39'b0, w.angle}) % FULL_TURN;
      mag = longint'({33'b0, w.magnitude});
      oang = ang;
      r.new_x = w.pos_x;
      r.new_y = w.pos_y;
      r.out_delta_x = w.delta_x;
      r.out_delta_y = w.delta_y;
      if (w.cmd == vdr_pkg::CMD_DISPLACE) begin
         if (w.polar) begin
            unit_vector(ang, c, s);
            r.new_x = clamp32(longint'(w.pos_x) + round_q30(mag * c));
            r.new_y = clamp32(longint'(w.pos_y) - round_q30(mag * s));
         end else begin
            r.new_x = clamp32(longint'(w.pos_x) + longint'(w.delta_x));
            r.new_y = clamp32(longint'(w.pos_y) - longint'(w.delta_y));
         end
      end else if (w.polar) begin
         if (w.side_wall) begin
            oang = (ang <= HALF_TURN) ? HALF_TURN - ang : FULL_TURN + HALF_TURN - ang;
         end else begin
            oang = (ang == 0) ? 0 : FULL_TURN - ang;
         end
      end else if (w.side_wall) begin
         r.out_delta_x = clamp32(-longint'(w.delta_x));
      end else begin
         r.out_delta_y = clamp32(-longint'(w.delta_y));
      end
      r.out_angle = oang[ANGLE_W-1:0];
      r.out_magnitude = w.magnitude;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return $urandom_range(0, 511) - 256;
         3: return COORD_MAX - $urandom_range(0, 1 << 20);
         4: return COORD_MIN + $urandom_range(0, 1 << 20);
         default: return $urandom();
      endcase
   endfunction

   function automatic longint pick_angle();
      int unsigned k;
      case ($urandom_range(0, 9))
         0: begin
            k = $urandom_range(0, 5);
            return longint'(k) * 90 * ONE_DEG;
         end
         1: return longint'($urandom());
         2: return longint'($urandom_range(0, 8));
         3: return FULL_TURN - 1 - longint'($urandom_range(0, 8));
         default: return longint'($urandom_range(0, 32'(FULL_TURN - 1)));
      endcase
   endfunction

   function automatic longint pick_magnitude();
      case ($urandom_range(0, 9))
         0: return MAG_MAX;
         1: return 0;
         2: return longint'($urandom_range(0, 1 << 20));
         3: return MAG_MAX - longint'($urandom_range(0, 1 << 20));
         default: return longint'($urandom());
      endcase
   endfunction

   task automatic queue_word(input logic cmd, input logic polar, input logic side,
                             input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] dx,
                             input logic signed [COORD_W-1:0] dy,
                             input longint ang,
                             input longint mag,
                             input int unsigned gap);
      motion_word_type w;
      w.cmd = cmd;
      w.polar = polar;
      w.side_wall = side;
      w.pos_x = px;
      w.pos_y = py;
      w.delta_x = dx;
      w.delta_y = dy;
      w.angle = ANGLE_W'(ang);
      w.magnitude = MAG_W'(mag);
      w.gap = gap;
      word_backlog.push_back(w);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_motion_q.push_back(predict_motion(live_word));
            kind_count[{live_word.cmd, live_word.polar}]++;
         end
         if (!start || !busy) begin
            if (!staged && word_backlog.size() != 0) begin
               staged_word = word_backlog.pop_front();
               staged = 1'b1;
               hold_left = staged_word.gap;
            end
            if (staged && hold_left == 0) begin
               req_cmd <= staged_word.cmd;
               req_polar <= staged_word.polar;
               req_side_wall <= staged_word.side_wall;
               req_pos_x <= staged_word.pos_x;
               req_pos_y <= staged_word.pos_y;
               req_delta_x <= staged_word.delta_x;
               req_delta_y <= staged_word.delta_y;
               req_angle <= staged_word.angle;
               req_magnitude <= staged_word.magnitude;
               live_word = staged_word;
               staged = 1'b0;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
               if (staged) hold_left--;
            end
         end
      end
   end

   always @(posedge clock) begin
      motion_result_type want;
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!reset && rsp_valid) begin
         if (predicted_motion_q.size() == 0) begin
            flag_mismatch("result word arrived with no prediction pending");
         end else begin
            want = predicted_motion_q.pop_front();
            check_field("new_x", longint'(rsp_new_x), longint'(want.new_x));
            check_field("new_y", longint'(rsp_new_y), longint'(want.new_y));
            check_field("out_delta_x", longint'(rsp_out_delta_x),
                        longint'(want.out_delta_x));
            check_field("out_delta_y", longint'(rsp_out_delta_y),
                        longint'(want.out_delta_y));
            check_field("out_angle", longint'(rsp_out_angle), longint'(want.out_angle));
            check_field("out_magnitude", longint'(rsp_out_magnitude),
                        longint'(want.out_magnitude));
            results_checked++;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int n;
      logic cmd;
      logic polar;
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MIN, ANGLE_TOP, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b0, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MAX, FULL_TURN - 1, 0, 1);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, 0, 0, 5, 7, 0, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, 0, 0, 0, 0, QUARTER, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b1, 0, 0, 0, 0, HALF_TURN, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, 0, 0, 0, 0, 3 * QUARTER, MAG_MAX, 2);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, 0, 0, 0, 0, 45 * ONE_DEG, 1 << 16, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, 1, 1, 0, 0, FULL_TURN - 1, 1 << 16, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, COORD_MAX, COORD_MIN, 0, 0, 0,
                 MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, COORD_MIN, COORD_MAX, 0, 0,
                 HALF_TURN + QUARTER, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b1, 100, -100, 3, 4, ANGLE_TOP, 0, 0);
      queue_word(vdr_pkg::CMD_DISPLACE, 1'b1, 1'b0, 0, 0, 0, 0, FULL_TURN + QUARTER,
                 12345678, 30);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b0, 1'b1, COORD_MAX, COORD_MIN, COORD_MIN, 9,
                 0, 0, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b0, 1'b0, 1, 2, 9, COORD_MIN, ANGLE_TOP,
                 MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b0, 1'b1, 0, 0, COORD_MAX, COORD_MAX,
                 FULL_TURN, 1, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b1, 3, 4, COORD_MIN, COORD_MAX, 0, 0, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b1, 0, 0, 0, 0, HALF_TURN, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b1, 0, 0, 0, 0, HALF_TURN + 1, 77, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b1, 0, 0, 0, 0, FULL_TURN - 1, 77, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b0, 0, 0, 0, 0, 0, 0, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b0, 0, 0, 0, 0, 1, 0, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b0, 0, 0, 0, 0, ANGLE_TOP, MAG_MAX, 0);
      queue_word(vdr_pkg::CMD_REFLECT, 1'b1, 1'b1, 0, 0, 0, 0, FULL_TURN + HALF_TURN,
                 0, 0);
      for (n = 0; n < RANDOM_WORDS; n++) begin
         cmd = 1'($urandom_range(0, 1));
         polar = 1'($urandom_range(0, 1));
         queue_word(cmd, polar, 1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_angle(), pick_magnitude(),
                    (n >= 300 && n < 450) ? 0 : pick_gap());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (word_backlog.size() != 0 || staged || start || predicted_motion_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Run covered %0d displace-cartesian, %0d displace-polar, %0d reflect-cartesian",
               kind_count[0], kind_count[1], kind_count[2]);
      $display("and %0d reflect-polar words; %0d result words checked, %0d mismatches.",
               kind_count[3], results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/vdr_pkg.sv
rtl/vector_displace_and_reflect.sv
bench/tb_top.sv
